FILE: rtl/glpf_pkg.sv
// Package for the grid local peak finder.
// Holds configuration register indexes, field widths and reset constants.
// No dependencies.
package glpf_pkg;

    localparam int CFG_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int OUT_W      = 5;
    localparam int DIM_RESET  = 32;
    localparam int DIM_MIN    = 2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_GRID_ROWS = t_cfg_idx'(0);
    localparam t_cfg_idx REG_GRID_COLS = t_cfg_idx'(1);

endpackage

FILE: rtl/grid_local_peak_finder.sv
// Top level of the grid local peak finder: raster-order four-neighbour peak detector.
// Depends on glpf_pkg for register indexes and field widths.
//
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  sample   | i_valid, o_stall, i_sample               | in
//  peak     | o_valid, i_stall, o_peak_row, o_peak_col | out
//  config   | i_cfg_valid, o_cfg_ready, i_cfg_index,   | in
//           | i_cfg_data                               |
//
// One request is taken per clock while o_stall is low; its peak decision lands in the
// output register on the same edge. The figure is set by the one read port of each line
// store, whose read for the next column is issued while the current request is taken.
// Reset is synchronous and restores 32 by 32 geometry; the line stores are not cleared.
// A held output stalls the input only when the output is stalled too.
// A write to the row or column register restarts the frame at row 0, column 0.
module grid_local_peak_finder
    import glpf_pkg::*;
#(
    parameter int MAX_COLS     = 32,
    parameter int MAX_ROWS     = 32,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [OUT_W-1:0]        o_peak_row,
    output logic [OUT_W-1:0]        o_peak_col,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  t_cfg_idx                i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data
);

    localparam int RC_W  = $clog2(MAX_ROWS + 1);
    localparam int CA_W  = $clog2(MAX_COLS);
    localparam int CD_W  = $clog2(MAX_COLS + 1);
    localparam int RE_W  = (RC_W > CFG_W) ? RC_W : CFG_W;
    localparam int CE_W  = (CD_W > CFG_W) ? CD_W : CFG_W;
    localparam int RX_W  = (RC_W > OUT_W) ? RC_W : OUT_W;
    localparam int CX_W  = (CA_W > OUT_W) ? CA_W : OUT_W;
    localparam int ROWS_RST = (DIM_RESET > MAX_ROWS) ? MAX_ROWS : DIM_RESET;
    localparam int COLS_RST = (DIM_RESET > MAX_COLS) ? MAX_COLS : DIM_RESET;

    logic [RC_W-1:0] r_rows;
    logic [CD_W-1:0] r_cols;
    logic [RC_W-1:0] r_row, n_row;
    logic [CA_W-1:0] r_col, n_col;

    logic signed [SAMPLE_WIDTH-1:0] r_mid;
    logic signed [SAMPLE_WIDTH-1:0] r_left;
    logic signed [SAMPLE_WIDTH-1:0] r_col0;

    logic signed [SAMPLE_WIDTH-1:0] mem_centre [MAX_COLS];
    logic signed [SAMPLE_WIDTH-1:0] mem_above  [MAX_COLS];
    logic signed [SAMPLE_WIDTH-1:0] r_rd_centre;
    logic signed [SAMPLE_WIDTH-1:0] r_rd_above;
    logic signed [SAMPLE_WIDTH-1:0] r_byp_data;
    logic                           r_byp;

    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out_row;
    logic [OUT_W-1:0]    r_out_col;

    logic                           accept;
    logic                           cfg_wr;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic signed [SAMPLE_WIDTH-1:0] centre;
    logic signed [SAMPLE_WIDTH-1:0] right;
    logic                           last_col;
    logic                           peak;
    logic [CA_W-1:0]                rd_addr;
    logic [RE_W-1:0]                cfg_rows_ext;
    logic [CE_W-1:0]                cfg_cols_ext;
    logic [RC_W-1:0]                cfg_rows;
    logic [CD_W-1:0]                cfg_cols;
    logic [RX_W-1:0]                row_m1;
    logic [CX_W-1:0]                col_ext;

    assign o_stall     = r_out_valid & i_stall;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid & ~o_stall;
    assign cfg_wr      = i_cfg_valid &
                         ((i_cfg_index == REG_GRID_ROWS) || (i_cfg_index == REG_GRID_COLS));
    assign sample      = $signed(i_sample);

    always_comb begin
        cfg_rows_ext = RE_W'(i_cfg_data);
        cfg_cols_ext = CE_W'(i_cfg_data);
        if (cfg_rows_ext < RE_W'(DIM_MIN)) begin
            cfg_rows_ext = RE_W'(DIM_MIN);
        end else if (cfg_rows_ext > RE_W'(MAX_ROWS)) begin
            cfg_rows_ext = RE_W'(MAX_ROWS);
        end
        if (cfg_cols_ext < CE_W'(DIM_MIN)) begin
            cfg_cols_ext = CE_W'(DIM_MIN);
        end else if (cfg_cols_ext > CE_W'(MAX_COLS)) begin
            cfg_cols_ext = CE_W'(MAX_COLS);
        end
        cfg_rows = cfg_rows_ext[RC_W-1:0];
        cfg_cols = cfg_cols_ext[CD_W-1:0];
    end

    // Column zero of the previous row is kept aside; other centre values come from the
    // prefetched right neighbour of the previous column.
    always_comb begin
        centre   = (r_col == '0) ? r_col0 : r_mid;
        right    = r_byp ? r_byp_data : r_rd_centre;
        last_col = ((CD_W'(r_col) + CD_W'(1)) == r_cols);
        peak     = (r_row != '0);
        if ((r_row >= RC_W'(2)) && (centre < r_rd_above)) begin
            peak = 1'b0;
        end
        if ((r_row < r_rows) && (centre < sample)) begin
            peak = 1'b0;
        end
        if ((r_col != '0) && (centre < r_left)) begin
            peak = 1'b0;
        end
        if (!last_col && (centre < right)) begin
            peak = 1'b0;
        end
        row_m1  = RX_W'(r_row) - RX_W'(1);
        col_ext = CX_W'(r_col);
    end

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (cfg_wr) begin
            n_row = '0;
            n_col = '0;
        end else if (accept) begin
            if (last_col) begin
                n_col = '0;
                n_row = (r_row == r_rows) ? '0 : r_row + RC_W'(1);
            end else begin
                n_col = r_col + CA_W'(1);
            end
        end
        rd_addr = (n_col == CA_W'(MAX_COLS - 1)) ? '0 : n_col + CA_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= RC_W'(ROWS_RST);
            r_cols <= CD_W'(COLS_RST);
            r_row  <= '0;
            r_col  <= '0;
        end else begin
            if (i_cfg_valid && (i_cfg_index == REG_GRID_ROWS)) begin
                r_rows <= cfg_rows;
            end
            if (i_cfg_valid && (i_cfg_index == REG_GRID_COLS)) begin
                r_cols <= cfg_cols;
            end
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_left <= centre;
            r_mid  <= right;
            if (r_col == '0) begin
                r_col0 <= sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            mem_centre[r_col] <= sample;
        end
        r_rd_centre <= mem_centre[rd_addr];
        r_byp       <= accept && (r_col == rd_addr);
        r_byp_data  <= sample;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            mem_above[r_col] <= centre;
        end
        r_rd_above <= mem_above[n_col];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= peak;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_row <= row_m1[OUT_W-1:0];
            r_out_col <= col_ext[OUT_W-1:0];
        end
    end

    assign o_valid    = r_out_valid;
    assign o_peak_row = r_out_row;
    assign o_peak_col = r_out_col;

endmodule
